/* hdl/rtm_pkg.sv */
// ----------------------------------------------------------------------------
// Repetition timing monitor package
// Item types, mode and action codes and field widths shared by the monitor.
// ----------------------------------------------------------------------------
package rtm_pkg;

  // Field widths.
  localparam int ActionW = 3;
  localparam int TimeW   = 64;
  localparam int BytesW  = 48;
  localparam int FreqW   = 40;
  localparam int SecW    = 16;
  localparam int CountW  = 32;
  localparam int ModeW   = 2;
  localparam int FlagW   = 4;

  // Action codes.
  localparam logic [ActionW-1:0] ACT_NEW_WAVE = 3'd0;
  localparam logic [ActionW-1:0] ACT_OPEN     = 3'd1;
  localparam logic [ActionW-1:0] ACT_CLOSE    = 3'd2;
  localparam logic [ActionW-1:0] ACT_BYTES    = 3'd3;
  localparam logic [ActionW-1:0] ACT_POLL     = 3'd4;

  // Mode codes.
  localparam logic [ModeW-1:0] MODE_UNINIT    = 2'd0;
  localparam logic [ModeW-1:0] MODE_TESTING   = 2'd1;
  localparam logic [ModeW-1:0] MODE_COMPLETED = 2'd2;
  localparam logic [ModeW-1:0] MODE_ERROR     = 2'd3;

  // Error flag bit positions.
  localparam int FLAG_TARGET = 0;
  localparam int FLAG_FREQ   = 1;
  localparam int FLAG_UNBAL  = 2;
  localparam int FLAG_BYTES  = 3;

  localparam logic [TimeW-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [TimeW-1:0]   timestamp;
    logic [BytesW-1:0]  byte_count;
    logic [BytesW-1:0]  wave_target_bytes;
    logic [FreqW-1:0]   wave_timer_freq;
    logic [SecW-1:0]    wave_seconds;
  } rtm_in_t;

  typedef struct packed {
    logic              testing;
    logic [ModeW-1:0]  mode_now;
    logic [FlagW-1:0]  error_flags;
    logic              new_minimum;
    logic [TimeW-1:0]  tests_done;
    logic [TimeW-1:0]  min_ticks;
    logic [TimeW-1:0]  max_ticks;
    logic [TimeW-1:0]  total_ticks;
  } rtm_out_t;

endpackage

/* hdl/repetition_timing_monitor_unit.sv */
// ----------------------------------------------------------------------------
// Repetition timing monitor
// Tracks timed test repetitions from timestamped events and reports status.
// ----------------------------------------------------------------------------
// The monitor takes one event per clock cycle while the output is not stalled
// and returns exactly one status item for each, in order; an event passes
// through the input register and then the result register.
// The rate is set by the core's state update, whose longest paths are the
// 16 by 40 bit window product of a new wave and the poll check (64-bit
// compare of the test time against the minimum and the window comparison).
// There is no clearing pass after reset; the block accepts events from the
// first cycle after reset is released.
module repetition_timing_monitor_unit
  import rtm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rtm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rtm_out_t out_data
);

  logic     advance;
  logic     ev_valid;
  rtm_in_t  ev_data;
  rtm_out_t result;

  // Input register.
  rtm_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .advance  (advance),
    .ev_valid (ev_valid),
    .ev_data  (ev_data)
  );

  // State and next-state logic; it steps only when the event moves on.
  rtm_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (ev_valid && advance),
    .ev     (ev_data),
    .result (result)
  );

  // Result register.
  rtm_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (ev_valid),
    .res_data  (result),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The input is only held off by a stalled result with an event waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (ev_valid && out_valid && !out_ready))
    else $error("input stalled without a stalled result");

  // Once a test is recorded the minimum never exceeds the maximum.
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.tests_done != '0)) |->
      (out_data.min_ticks <= out_data.max_ticks))
    else $error("minimum above maximum");

  // A new minimum only comes from a clean poll that keeps testing.
  a_newmin_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.new_minimum) |->
      ((out_data.error_flags == '0) && (out_data.mode_now == MODE_TESTING)))
    else $error("new minimum with errors or outside testing");

endmodule

/* hdl/rtm_in_stage.sv */
// ----------------------------------------------------------------------------
// Monitor input register
// Holds one accepted event until the core has processed it.
// ----------------------------------------------------------------------------
module rtm_in_stage
  import rtm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  rtm_in_t in_data,
  input  logic    advance,
  output logic    ev_valid,
  output rtm_in_t ev_data
);

  logic    ev_valid_r;
  logic    ev_valid_nxt;
  rtm_in_t ev_data_r;

  // The register frees up whenever its item moves on to the core.
  assign in_ready = !ev_valid_r || advance;

  always_comb begin
    ev_valid_nxt = ev_valid_r;
    if (in_ready) begin
      ev_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r <= 1'b0;
    end else begin
      ev_valid_r <= ev_valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ev_data_r <= in_data;
    end
  end

  assign ev_valid = ev_valid_r;
  assign ev_data  = ev_data_r;

endmodule

/* hdl/rtm_core.sv */
// ----------------------------------------------------------------------------
// Monitor core
// Holds the test state and works out its next value and the status item for
// one event combinationally.
// ----------------------------------------------------------------------------
module rtm_core
  import rtm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  rtm_in_t  ev,
  output rtm_out_t result
);

  logic [ModeW-1:0]  mode_r,         mode_nxt;
  logic [BytesW-1:0] target_bytes_r, target_bytes_nxt;
  logic [FreqW-1:0]  timer_freq_r,   timer_freq_nxt;
  logic [TimeW-1:0]  window_ticks_r, window_ticks_nxt;
  logic [TimeW-1:0]  window_start_r, window_start_nxt;
  logic [CountW-1:0] opens_r,        opens_nxt;
  logic [CountW-1:0] closes_r,       closes_nxt;
  logic [TimeW-1:0]  test_ticks_r,   test_ticks_nxt;
  logic [TimeW-1:0]  test_bytes_r,   test_bytes_nxt;
  logic [TimeW-1:0]  count_done_r,   count_done_nxt;
  logic [TimeW-1:0]  sum_ticks_r,    sum_ticks_nxt;
  logic [TimeW-1:0]  largest_r,      largest_nxt;
  logic [TimeW-1:0]  smallest_r,     smallest_nxt;

  logic [FlagW-1:0]      flags;
  logic                  newmin;
  logic [SecW+FreqW-1:0] window_prod;
  logic [TimeW-1:0]      elapsed;
  logic                  unbalanced;
  logic                  mismatch;

  // Trial window length for a new wave; only a later poll reads it.
  assign window_prod = {{FreqW{1'b0}}, ev.wave_seconds} *
                       {{SecW{1'b0}}, ev.wave_timer_freq};

  // Time since the window opened, and the closing checks of a test.
  assign elapsed    = ev.timestamp - window_start_r;
  assign unbalanced = (opens_r != closes_r);
  assign mismatch   = (test_bytes_r != {{(TimeW-BytesW){1'b0}}, target_bytes_r});

  // Next state for the event.
  always_comb begin
    mode_nxt         = mode_r;
    target_bytes_nxt = target_bytes_r;
    timer_freq_nxt   = timer_freq_r;
    window_ticks_nxt = window_ticks_r;
    window_start_nxt = window_start_r;
    opens_nxt        = opens_r;
    closes_nxt       = closes_r;
    test_ticks_nxt   = test_ticks_r;
    test_bytes_nxt   = test_bytes_r;
    count_done_nxt   = count_done_r;
    sum_ticks_nxt    = sum_ticks_r;
    largest_nxt      = largest_r;
    smallest_nxt     = smallest_r;
    flags            = '0;
    newmin           = 1'b0;

    case (ev.action)
      ACT_NEW_WAVE: begin
        if (mode_r == MODE_UNINIT) begin
          mode_nxt         = MODE_TESTING;
          target_bytes_nxt = ev.wave_target_bytes;
          timer_freq_nxt   = ev.wave_timer_freq;
          smallest_nxt     = ALL_ONES;
        end else if (mode_r == MODE_COMPLETED) begin
          // A changed wave setup is an error; the stored setup stays.
          mode_nxt = MODE_TESTING;
          if (target_bytes_r != ev.wave_target_bytes) begin
            flags[FLAG_TARGET] = 1'b1;
            mode_nxt           = MODE_ERROR;
          end
          if (timer_freq_r != ev.wave_timer_freq) begin
            flags[FLAG_FREQ] = 1'b1;
            mode_nxt         = MODE_ERROR;
          end
        end
        window_ticks_nxt = {{(TimeW-SecW-FreqW){1'b0}}, window_prod};
        window_start_nxt = ev.timestamp;
      end
      ACT_OPEN: begin
        opens_nxt      = opens_r + CountW'(1);
        test_ticks_nxt = test_ticks_r - ev.timestamp;
      end
      ACT_CLOSE: begin
        closes_nxt     = closes_r + CountW'(1);
        test_ticks_nxt = test_ticks_r + ev.timestamp;
      end
      ACT_BYTES: begin
        test_bytes_nxt = test_bytes_r + {{(TimeW-BytesW){1'b0}}, ev.byte_count};
      end
      ACT_POLL: begin
        if (mode_r == MODE_TESTING) begin
          if (opens_r != '0) begin
            flags[FLAG_UNBAL] = unbalanced;
            flags[FLAG_BYTES] = mismatch;
            if (unbalanced || mismatch) begin
              mode_nxt = MODE_ERROR;
            end else begin
              // Record the test and clear the accumulators.
              count_done_nxt = count_done_r + TimeW'(1);
              sum_ticks_nxt  = sum_ticks_r + test_ticks_r;
              if (largest_r < test_ticks_r) begin
                largest_nxt = test_ticks_r;
              end
              if (smallest_r > test_ticks_r) begin
                smallest_nxt     = test_ticks_r;
                window_start_nxt = ev.timestamp;
                newmin           = 1'b1;
              end
              opens_nxt      = '0;
              closes_nxt     = '0;
              test_ticks_nxt = '0;
              test_bytes_nxt = '0;
            end
          end
          // A new minimum reopens the window, so it cannot expire now.
          if (!newmin && (elapsed > window_ticks_r)) begin
            mode_nxt = MODE_COMPLETED;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // State registers, updated once per processed event.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_UNINIT;
      target_bytes_r <= '0;
      timer_freq_r   <= '0;
      window_ticks_r <= '0;
      window_start_r <= '0;
      opens_r        <= '0;
      closes_r       <= '0;
      test_ticks_r   <= '0;
      test_bytes_r   <= '0;
      count_done_r   <= '0;
      sum_ticks_r    <= '0;
      largest_r      <= '0;
      smallest_r     <= ALL_ONES;
    end else if (fire) begin
      mode_r         <= mode_nxt;
      target_bytes_r <= target_bytes_nxt;
      timer_freq_r   <= timer_freq_nxt;
      window_ticks_r <= window_ticks_nxt;
      window_start_r <= window_start_nxt;
      opens_r        <= opens_nxt;
      closes_r       <= closes_nxt;
      test_ticks_r   <= test_ticks_nxt;
      test_bytes_r   <= test_bytes_nxt;
      count_done_r   <= count_done_nxt;
      sum_ticks_r    <= sum_ticks_nxt;
      largest_r      <= largest_nxt;
      smallest_r     <= smallest_nxt;
    end
  end

  // Status after this event.
  always_comb begin
    result.testing     = (mode_nxt == MODE_TESTING);
    result.mode_now    = mode_nxt;
    result.error_flags = flags;
    result.new_minimum = newmin;
    result.tests_done  = count_done_nxt;
    result.min_ticks   = smallest_nxt;
    result.max_ticks   = largest_nxt;
    result.total_ticks = sum_ticks_nxt;
  end

endmodule

/* hdl/rtm_out_stage.sv */
// ----------------------------------------------------------------------------
// Monitor result register
// Holds one status item until the consumer takes it.
// ----------------------------------------------------------------------------
module rtm_out_stage
  import rtm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     res_valid,
  input  rtm_out_t res_data,
  output logic     advance,
  output logic     out_valid,
  input  logic     out_ready,
  output rtm_out_t out_data
);

  logic     out_valid_r;
  logic     out_valid_nxt;
  rtm_out_t out_data_r;

  // The register can take a new item when empty or being emptied.
  assign advance = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Repetition timing monitor testbench
// Drives timestamped events into the monitor through its valid/ready input,
// predicts every status item with an internal model of the test bookkeeping
// and compares each returned item field by field. Most of the stimulus is
// well-formed test repetitions (open, close and add-bytes events closed by a
// poll), mixed with ignored codes, stray polls, wave restarts, deliberately
// spoilt tests that escape through an expired window, and a closing stretch
// that drives the monitor into its error mode. Both sides of the block stall
// at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rtm_pkg::*;

  localparam int ACT_UNDEF_FIRST = ACT_POLL + 1;
  localparam int ACT_CODE_LAST   = (1 << ActionW) - 1;
  localparam logic [FreqW-1:0] FREQ_MAX = '1;
  localparam logic [SecW-1:0]  SECS_MAX = '1;
  localparam logic [BytesW-1:0] BYTES_MAX = '1;

  // Keeps the expected status of every accepted event and checks the block.
  class status_scoreboard;
    logic [ModeW-1:0]  mode;
    logic [BytesW-1:0] target_bytes;
    logic [FreqW-1:0]  timer_freq;
    logic [TimeW-1:0]  window_ticks;
    logic [TimeW-1:0]  window_start;
    logic [CountW-1:0] opens;
    logic [CountW-1:0] closes;
    logic [TimeW-1:0]  test_ticks;
    logic [TimeW-1:0]  test_bytes;
    logic [TimeW-1:0]  count_done;
    logic [TimeW-1:0]  sum_ticks;
    logic [TimeW-1:0]  largest;
    logic [TimeW-1:0]  smallest;
    rtm_out_t          expected_status[$];
    int unsigned       mismatches;
    int unsigned       minima_seen;
    int unsigned       completions;
    int unsigned       flagged_steps;

    function new();
      mode         = MODE_UNINIT;
      target_bytes = '0;
      timer_freq   = '0;
      window_ticks = '0;
      window_start = '0;
      opens        = '0;
      closes       = '0;
      test_ticks   = '0;
      test_bytes   = '0;
      count_done   = '0;
      sum_ticks    = '0;
      largest      = '0;
      smallest     = ALL_ONES;
      mismatches   = 0;
      minima_seen  = 0;
      completions  = 0;
      flagged_steps = 0;
    endfunction

    // Advances the bookkeeping by one accepted event and queues its status.
    function void note_event(rtm_in_t ev);
      logic [FlagW-1:0] flags;
      logic             fresh_min;
      logic [ModeW-1:0] mode_was;
      rtm_out_t         status;
      flags     = '0;
      fresh_min = 1'b0;
      mode_was  = mode;
      case (ev.action)
        ACT_NEW_WAVE: begin
          if (mode == MODE_UNINIT) begin
            mode         = MODE_TESTING;
            target_bytes = ev.wave_target_bytes;
            timer_freq   = ev.wave_timer_freq;
            smallest     = ALL_ONES;
          end else if (mode == MODE_COMPLETED) begin
            mode = MODE_TESTING;
            if (target_bytes != ev.wave_target_bytes) begin
              flags[FLAG_TARGET] = 1'b1;
              mode = MODE_ERROR;
            end
            if (timer_freq != ev.wave_timer_freq) begin
              flags[FLAG_FREQ] = 1'b1;
              mode = MODE_ERROR;
            end
          end
          window_ticks = TimeW'(ev.wave_seconds) * TimeW'(ev.wave_timer_freq);
          window_start = ev.timestamp;
        end
        ACT_OPEN: begin
          opens      = opens + 1'b1;
          test_ticks = test_ticks - ev.timestamp;
        end
        ACT_CLOSE: begin
          closes     = closes + 1'b1;
          test_ticks = test_ticks + ev.timestamp;
        end
        ACT_BYTES: begin
          test_bytes = test_bytes + TimeW'(ev.byte_count);
        end
        ACT_POLL: begin
          if (mode == MODE_TESTING) begin
            // A test only counts once a block has been opened in it.
            if (opens != '0) begin
              if (opens != closes) begin
                flags[FLAG_UNBAL] = 1'b1;
                mode = MODE_ERROR;
              end
              if (test_bytes != TimeW'(target_bytes)) begin
                flags[FLAG_BYTES] = 1'b1;
                mode = MODE_ERROR;
              end
              if (mode == MODE_TESTING) begin
                count_done = count_done + 1'b1;
                sum_ticks  = sum_ticks + test_ticks;
                if (largest < test_ticks) largest = test_ticks;
                if (smallest > test_ticks) begin
                  smallest     = test_ticks;
                  window_start = ev.timestamp;
                  fresh_min    = 1'b1;
                end
                opens      = '0;
                closes     = '0;
                test_ticks = '0;
                test_bytes = '0;
              end
            end
            // The window check runs even after an error on this poll.
            if (ev.timestamp - window_start > window_ticks) mode = MODE_COMPLETED;
          end
        end
        default: begin
          // Undefined codes leave the state alone and only report it.
        end
      endcase
      status.testing     = (mode == MODE_TESTING);
      status.mode_now    = mode;
      status.error_flags = flags;
      status.new_minimum = fresh_min;
      status.tests_done  = count_done;
      status.min_ticks   = smallest;
      status.max_ticks   = largest;
      status.total_ticks = sum_ticks;
      expected_status.push_back(status);
      if (fresh_min) minima_seen++;
      if (flags != '0) flagged_steps++;
      if (mode == MODE_COMPLETED && mode_was != MODE_COMPLETED) completions++;
    endfunction

    function void compare_field(string name, logic [TimeW-1:0] want, logic [TimeW-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    // Compares a returned status item with the oldest one outstanding.
    function void check_status(rtm_out_t got);
      rtm_out_t want;
      if (expected_status.size() == 0) begin
        $error("status item returned with none outstanding");
        mismatches++;
        return;
      end
      want = expected_status.pop_front();
      compare_field("testing", want.testing, got.testing);
      compare_field("mode_now", want.mode_now, got.mode_now);
      compare_field("error_flags", want.error_flags, got.error_flags);
      compare_field("new_minimum", want.new_minimum, got.new_minimum);
      compare_field("tests_done", want.tests_done, got.tests_done);
      compare_field("min_ticks", want.min_ticks, got.min_ticks);
      compare_field("max_ticks", want.max_ticks, got.max_ticks);
      compare_field("total_ticks", want.total_ticks, got.total_ticks);
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  rtm_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  rtm_out_t out_data;

  status_scoreboard sb;
  logic [TimeW-1:0] clock_now;
  int unsigned      events_sent = 0;
  int unsigned      tx_idle_pct = 18;
  int unsigned      rx_idle_pct = 75;
  int unsigned      stalls_asked = 0;
  int unsigned      stalls_done = 0;
  int unsigned      stall_left = 0;

  repetition_timing_monitor_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Result side: random back-pressure, plus a long hold-off when asked.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_asked != stalls_done) begin
      out_ready   <= 1'b0;
      stall_left  <= 300;
      stalls_done <= stalls_done + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_status(out_data);
  end

  // Safety net in case the block stops handing items over.
  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [TimeW-1:0] rand_bits64();
    return {$urandom(), $urandom()};
  endfunction

  // Builds an event with random contents in the fields that it does not use.
  function automatic rtm_in_t make_event(input logic [ActionW-1:0] act,
                                         input logic [TimeW-1:0] ts);
    rtm_in_t ev;
    ev.action            = act;
    ev.timestamp         = ts;
    ev.byte_count        = BytesW'(rand_bits64());
    ev.wave_target_bytes = BytesW'(rand_bits64());
    ev.wave_timer_freq   = FreqW'(rand_bits64());
    ev.wave_seconds      = SecW'($urandom());
    return ev;
  endfunction

  // Offers one item after a random gap and holds it until it is taken.
  task automatic send_event(input rtm_in_t ev);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (!in_ready);
    sb.note_event(ev);
    if (ev.action <= ACT_POLL) events_sent++;
  endtask

  task automatic send_mark(input logic [ActionW-1:0] act);
    send_event(make_event(act, clock_now));
  endtask

  task automatic send_bytes(input logic [BytesW-1:0] amount);
    rtm_in_t ev;
    ev = make_event(ACT_BYTES, clock_now);
    ev.byte_count = amount;
    send_event(ev);
  endtask

  task automatic send_wave(input logic [BytesW-1:0] tgt, input logic [FreqW-1:0] freq,
                           input logic [SecW-1:0] secs);
    rtm_in_t ev;
    ev = make_event(ACT_NEW_WAVE, clock_now);
    ev.wave_target_bytes = tgt;
    ev.wave_timer_freq   = freq;
    ev.wave_seconds      = secs;
    send_event(ev);
  endtask

  function automatic logic [SecW-1:0] short_window_secs();
    if ($urandom_range(0, 3) == 0) return SecW'($urandom_range(200, 2000));
    return SecW'($urandom_range(0, 40));
  endfunction

  function automatic logic [TimeW-1:0] bytes_missing();
    if (sb.test_bytes < TimeW'(sb.target_bytes)) return TimeW'(sb.target_bytes) - sb.test_bytes;
    return '0;
  endfunction

  // Stray items that must not spoil the test in progress.
  task automatic send_noise();
    rtm_in_t ev;
    case ($urandom_range(0, 3))
      0: send_bytes('0);
      1: begin
        if (sb.opens == '0) send_mark(ACT_POLL);
        else send_event(make_event(ActionW'($urandom_range(ACT_UNDEF_FIRST, ACT_CODE_LAST)),
                                   rand_bits64()));
      end
      2: begin
        // A restart while testing only moves the window.
        if (sb.mode == MODE_TESTING) send_wave(BytesW'(rand_bits64()), FreqW'(rand_bits64()),
                                               SecW'($urandom()));
        else send_mark(ACT_POLL);
      end
      default: begin
        ev = make_event(ActionW'($urandom_range(ACT_UNDEF_FIRST, ACT_CODE_LAST)), rand_bits64());
        send_event(ev);
      end
    endcase
  endtask

  // Between timed blocks: part of the byte budget, the odd stray item, or nothing.
  task automatic sprinkle();
    logic [TimeW-1:0] gap;
    int unsigned      pick;
    gap  = bytes_missing();
    pick = $urandom_range(0, 99);
    if (pick < 30 && gap != '0) send_bytes(BytesW'(rand_bits64() % (gap + 1)));
    else if (pick < 38) send_noise();
  endtask

  // One test repetition: timed blocks, bytes, then the poll that closes it.
  task automatic run_test_sequence();
    int unsigned      pairs;
    logic [1:0]       spoil;
    logic [TimeW-1:0] gap;
    logic [TimeW-1:0] elapsed;
    spoil = ($urandom_range(0, 99) < 4) ? 2'($urandom_range(1, 3)) : 2'b00;
    clock_now += $urandom_range(0, 40);
    if (sb.mode == MODE_COMPLETED) begin
      send_wave(sb.target_bytes, sb.timer_freq, short_window_secs());
    end else if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 2) == 0) send_wave(BytesW'(rand_bits64()), FreqW'(rand_bits64()),
                                               SecW'($urandom()));
      else send_wave(sb.target_bytes, sb.timer_freq, short_window_secs());
    end
    sprinkle();
    pairs = $urandom_range(1, 3);
    repeat (pairs) begin
      clock_now += $urandom_range(0, 40);
      send_mark(ACT_OPEN);
      sprinkle();
      clock_now += $urandom_range(1, 700);
      send_mark(ACT_CLOSE);
      sprinkle();
    end
    // Square the books left by this or an earlier spoilt test.
    while (sb.closes < sb.opens) send_mark(ACT_CLOSE);
    while (sb.opens < sb.closes) send_mark(ACT_OPEN);
    if (spoil[0]) send_mark(ACT_OPEN);
    gap = bytes_missing();
    if (spoil[1] && gap != '0) gap = gap - 1'b1;
    if (gap != '0) send_bytes(BytesW'(gap));
    clock_now += $urandom_range(0, 40);
    // A spoilt test is polled after the window has run out, so that the
    // monitor goes to completed and not to its error mode.
    if (spoil != 2'b00) begin
      elapsed = clock_now - sb.window_start;
      if (elapsed <= sb.window_ticks)
        clock_now += sb.window_ticks - elapsed + 1 + $urandom_range(0, 30);
    end
    send_mark(ACT_POLL);
  endtask

  // Closing stretch: drive the monitor into its error mode, which it keeps.
  task automatic finish_in_error();
    if ($urandom_range(0, 1) == 0) begin
      // Unbalanced blocks and a byte mismatch inside a long window.
      if (sb.mode == MODE_COMPLETED) send_wave(sb.target_bytes, sb.timer_freq, SECS_MAX);
      else send_wave(BytesW'(rand_bits64()), FREQ_MAX, SECS_MAX);
      clock_now += 10;
      send_mark(ACT_OPEN);
      clock_now += 10;
      send_mark(ACT_OPEN);
      clock_now += 10;
      send_mark(ACT_CLOSE);
      send_bytes(BYTES_MAX);
      clock_now += 10;
      send_mark(ACT_POLL);
    end else begin
      // Let the window run out, then restart with both settings changed.
      while (sb.mode != MODE_COMPLETED) begin
        send_wave(sb.target_bytes, '0, '0);
        clock_now += 5;
        send_mark(ACT_POLL);
      end
      send_wave(sb.target_bytes ^ BytesW'($urandom_range(1, 255)),
                sb.timer_freq ^ FreqW'($urandom_range(1, 255)), short_window_secs());
    end
    send_bytes(BYTES_MAX);
    repeat (20) send_event(make_event(ActionW'($urandom_range(0, ACT_CODE_LAST)), rand_bits64()));
  endtask

  // Directed opening: every mode but error, each action and the wrap-around cases.
  task automatic run_directed();
    rtm_in_t          ev;
    logic [BytesW-1:0] tgt;
    logic [FreqW-1:0]  freq;
    tgt  = BytesW'(rand_bits64()) | BytesW'(1);
    freq = FreqW'($urandom_range(1, 8));
    // Poll and undefined codes before any wave.
    send_event(make_event(ACT_POLL, '0));
    ev = '1;
    ev.action = ActionW'(ACT_UNDEF_FIRST);
    send_event(ev);
    ev = '0;
    ev.action = ActionW'(ACT_CODE_LAST);
    send_event(ev);
    // A block spanning the timer wrap, while still uninitialised.
    send_event(make_event(ACT_OPEN, ALL_ONES));
    send_event(make_event(ACT_CLOSE, TimeW'(999)));
    // First wave, then a test made of the block above.
    clock_now = 100;
    send_wave(tgt, freq, SecW'(100));
    clock_now += 10;
    send_bytes(tgt);
    clock_now += 10;
    send_mark(ACT_POLL);
    // Poll with no block opened, inside the window.
    clock_now += 5;
    send_mark(ACT_POLL);
    // Restarts while testing: widest window, then an empty one.
    send_wave(BytesW'(rand_bits64()), FREQ_MAX, SECS_MAX);
    send_wave(tgt, '0, '0);
    clock_now += 1;
    send_mark(ACT_OPEN);
    clock_now += 2500;
    send_mark(ACT_CLOSE);
    send_bytes(tgt);
    clock_now += 1;
    send_mark(ACT_POLL);
    // Completed: poll does nothing, blocks still count.
    send_mark(ACT_POLL);
    clock_now += 3;
    send_mark(ACT_OPEN);
    clock_now += 40;
    send_mark(ACT_CLOSE);
    // Restart from completed with unchanged settings, near the top of the timer.
    clock_now = ALL_ONES - TimeW'($urandom_range(0, 200000));
    send_wave(tgt, freq, SecW'(100));
  endtask

  initial begin
    sb = new();
    clock_now = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    while (events_sent < 1150) begin
      if (events_sent >= 400 && tx_idle_pct == 18) begin
        tx_idle_pct = 75;
        rx_idle_pct = 18;
      end
      if (events_sent >= 780 && tx_idle_pct != 0) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        stalls_asked++;
      end
      run_test_sequence();
    end
    finish_in_error();
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain the outstanding status items, then allow for the pipeline.
    while (sb.expected_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d events, %0d recorded tests and %0d new minima.",
             events_sent, sb.count_done, sb.minima_seen);
    $display("The window ran out %0d times and %0d items carried error flags.",
             sb.completions, sb.flagged_steps);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* repetition_timing_monitor_unit.f */
hdl/rtm_pkg.sv
hdl/rtm_in_stage.sv
hdl/rtm_core.sv
hdl/rtm_out_stage.sv
hdl/repetition_timing_monitor_unit.sv
tb/testbench.sv
